[sv/dcrf_pkg.sv]
// Package with the shared types and constants of the distance constraint record filter.
`default_nettype none
package dcrf_pkg;

    localparam int DEF_MAX_CONSTRAINTS = 16;
    localparam int DEF_MAX_LOOP        = 64;
    localparam int DEF_MAX_SIDE        = 32;
    localparam int CHAIN_BYTES         = 6;
    localparam int CHAIN_W             = CHAIN_BYTES * 8;
    localparam int QUEUE_DEPTH         = 2;

    // Configuration register indexes.
    localparam logic [1:0] REG_LOOP_LENGTH = 2'd0;
    localparam logic [1:0] REG_DIST_SIDE   = 2'd1;

    // Item operation, one per mode code.
    typedef enum logic [1:0] {
        OP_LOAD_PLUS  = 2'd0,
        OP_LOAD_MINUS = 2'd1,
        OP_ELEMENT    = 2'd2,
        OP_CLEAR      = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [5:0]         constraint_number;
        logic signed [15:0] min_dist;
        logic signed [15:0] max_dist;
        logic [5:0]         element_column;
        logic signed [15:0] distance;
        logic [31:0]        record_id;
        logic [CHAIN_W-1:0] chain_id;
        logic               last_element;
    } in_t;

    typedef struct packed {
        logic [31:0] current_record;
        logic        plus_ok;
        logic        back_checked;
        logic [31:0] back_record;
        logic        back_remove;
        logic        table_overflow;
    } out_t;

    // Classified item as it waits in the queue.
    typedef struct packed {
        op_t op;
        in_t item;
    } cmd_t;

    typedef struct packed {
        logic [6:0] loop_length;
        logic [5:0] distances_per_side;
    } cfg_t;

endpackage
`default_nettype wire

[sv/dcrf_front.sv]
// Front end: accepts input beats, classifies them and queues them for the back end.
`default_nettype none
module dcrf_front
    import dcrf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire in_t  in_data,
    output logic      cmd_valid,
    output cmd_t      cmd,
    input  wire logic cmd_pop,
    output logic [1:0] level
);

    logic [1:0] count_reg, count_next;
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    cmd_t       q_reg [QUEUE_DEPTH];
    logic       push;
    logic       pop;

    assign in_stall  = (count_reg == 2'(QUEUE_DEPTH));
    assign push      = in_valid && !in_stall;
    assign pop       = cmd_pop && (count_reg != 2'd0);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];
    assign level     = count_reg;

    // Queue pointers and fill level.
    always_comb
    begin
        count_next = count_reg + 2'(push) - 2'(pop);
        rd_next    = rd_reg ^ pop;
        wr_next    = wr_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
        end
    end

    // Queue storage; the mode code is decoded into an operation on entry.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg].op   <= op_t'(in_data.mode);
            q_reg[wr_reg].item <= in_data;
        end
    end

endmodule
`default_nettype wire

[sv/dcrf_back.sv]
// Back end: constraint tables, range checks, key ring and the result register.
`default_nettype none
module dcrf_back
    import dcrf_pkg::*;
#(
    parameter int MAX_CONSTRAINTS = DEF_MAX_CONSTRAINTS,
    parameter int MAX_LOOP        = DEF_MAX_LOOP,
    parameter int MAX_SIDE        = DEF_MAX_SIDE
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic cmd_valid,
    input  wire cmd_t cmd,
    output logic      cmd_pop,
    output logic      out_valid,
    input  wire logic out_stall,
    output out_t      out_data
);

    localparam int CW   = $clog2(MAX_CONSTRAINTS + 1);
    localparam int IW   = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1;
    localparam int PW   = (MAX_LOOP > 1) ? $clog2(MAX_LOOP) : 1;
    localparam int LW0  = $clog2(MAX_LOOP + 1);
    localparam int LENW = (LW0 > 7) ? LW0 : 7;

    typedef struct packed {
        logic [5:0]         col;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
    } cons_t;

    typedef struct packed {
        logic [31:0]        rec;
        logic [CHAIN_W-1:0] chain;
    } ring_t;

    cons_t      plus_tab_reg  [MAX_CONSTRAINTS];
    cons_t      minus_tab_reg [MAX_CONSTRAINTS];
    logic [CW-1:0] plus_cnt_reg, minus_cnt_reg;
    logic       plus_acc_reg, minus_acc_reg;
    logic       ovf_reg;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic       filled_reg, filled_next;
    ring_t      ring_mem [MAX_LOOP];
    ring_t      rdata_reg;

    // Result stage.
    logic        res_valid_reg;
    logic [31:0] res_rec_reg;
    logic [CHAIN_W-1:0] res_chain_reg;
    logic        res_plus_reg;
    logic        res_minus_reg;
    logic        res_filled_reg;
    logic        res_byp_reg;
    logic        res_ovf_reg;

    in_t         it;
    logic        is_elem, is_last, col_in;
    logic [5:0]  side_eff;
    logic [LENW-1:0] len_eff;
    logic [LENW-1:0] ptr_inc;
    logic [6:0]  col7;
    logic        plus_fail, minus_fail;
    logic        plus_now, minus_now;
    ring_t       wr_ent;

    assign it      = cmd.item;
    assign cmd_pop = cmd_valid && (!res_valid_reg || !out_stall);
    assign is_elem = cmd_pop && (cmd.op == OP_ELEMENT);
    assign is_last = is_elem && it.last_element;
    assign wr_ent  = '{rec: it.record_id, chain: it.chain_id};

    // Saturated register values.
    always_comb
    begin
        if (cfg.distances_per_side == 6'd0)
            side_eff = 6'd1;
        else if ({1'b0, cfg.distances_per_side} > 7'(MAX_SIDE))
            side_eff = 6'(MAX_SIDE);
        else
            side_eff = cfg.distances_per_side;
        if (cfg.loop_length == 7'd0)
            len_eff = LENW'(1);
        else if (LENW'(cfg.loop_length) > LENW'(MAX_LOOP))
            len_eff = LENW'(MAX_LOOP);
        else
            len_eff = LENW'(cfg.loop_length);
    end

    // Parallel range checks against every loaded constraint.
    always_comb
    begin
        col7       = {1'b0, it.element_column};
        col_in     = col7 < {side_eff, 1'b0};
        plus_fail  = 1'b0;
        minus_fail = 1'b0;
        for (int i = 0; i < MAX_CONSTRAINTS; i++)
        begin
            if ((CW'(i) < plus_cnt_reg) && (plus_tab_reg[i].col != 6'd0)
                && ({1'b0, plus_tab_reg[i].col} == col7 + 7'd1)
                && ((it.distance < plus_tab_reg[i].lo) || (it.distance > plus_tab_reg[i].hi)))
                plus_fail = 1'b1;
            if ((CW'(i) < minus_cnt_reg) && (minus_tab_reg[i].col != 6'd0)
                && ({1'b0, minus_tab_reg[i].col} + {1'b0, side_eff} == col7 + 7'd1)
                && ((it.distance < minus_tab_reg[i].lo)
                    || (it.distance > minus_tab_reg[i].hi)))
                minus_fail = 1'b1;
        end
        plus_now  = plus_acc_reg && !(col_in && plus_fail);
        minus_now = minus_acc_reg && !(col_in && minus_fail);
    end

    // Ring pointer advance.
    always_comb
    begin
        ptr_inc     = LENW'(ptr_reg) + LENW'(1);
        ptr_next    = ptr_reg;
        filled_next = filled_reg;
        if (is_last)
        begin
            if (ptr_inc >= len_eff)
            begin
                ptr_next    = '0;
                filled_next = 1'b1;
            end
            else
            begin
                ptr_next = ptr_inc[PW-1:0];
            end
        end
    end

    // Control state, tables bookkeeping and result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plus_cnt_reg   <= '0;
            minus_cnt_reg  <= '0;
            plus_acc_reg   <= 1'b1;
            minus_acc_reg  <= 1'b1;
            ovf_reg        <= 1'b0;
            ptr_reg        <= '0;
            filled_reg     <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            ptr_reg    <= ptr_next;
            filled_reg <= filled_next;
            if (res_valid_reg && !out_stall)
                res_valid_reg <= 1'b0;
            if (cmd_pop)
            begin
                unique case (cmd.op)
                    OP_LOAD_PLUS:
                    begin
                        if (plus_cnt_reg >= CW'(MAX_CONSTRAINTS))
                            ovf_reg <= 1'b1;
                        else
                            plus_cnt_reg <= plus_cnt_reg + CW'(1);
                    end
                    OP_LOAD_MINUS:
                    begin
                        if (minus_cnt_reg >= CW'(MAX_CONSTRAINTS))
                            ovf_reg <= 1'b1;
                        else
                            minus_cnt_reg <= minus_cnt_reg + CW'(1);
                    end
                    OP_CLEAR:
                    begin
                        plus_cnt_reg  <= '0;
                        minus_cnt_reg <= '0;
                        ovf_reg       <= 1'b0;
                    end
                    OP_ELEMENT:
                    begin
                        if (it.last_element)
                        begin
                            plus_acc_reg  <= 1'b1;
                            minus_acc_reg <= 1'b1;
                            res_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            plus_acc_reg  <= plus_now;
                            minus_acc_reg <= minus_now;
                        end
                    end
                endcase
            end
        end
    end

    // Table entry writes and the payload of the result stage.
    always_ff @(posedge clk)
    begin
        if (cmd_pop && (cmd.op == OP_LOAD_PLUS) && (plus_cnt_reg < CW'(MAX_CONSTRAINTS)))
            plus_tab_reg[plus_cnt_reg[IW-1:0]] <= '{col: it.constraint_number,
                                                    lo: it.min_dist, hi: it.max_dist};
        if (cmd_pop && (cmd.op == OP_LOAD_MINUS) && (minus_cnt_reg < CW'(MAX_CONSTRAINTS)))
            minus_tab_reg[minus_cnt_reg[IW-1:0]] <= '{col: it.constraint_number,
                                                      lo: it.min_dist, hi: it.max_dist};
        if (is_last)
        begin
            res_rec_reg    <= it.record_id;
            res_chain_reg  <= it.chain_id;
            res_plus_reg   <= plus_now;
            res_minus_reg  <= minus_now;
            res_filled_reg <= filled_next;
            res_byp_reg    <= (ptr_next == ptr_reg);
            res_ovf_reg    <= ovf_reg;
        end
    end

    // Key ring: write the current key, read the key loop_length-1 records back.
    always_ff @(posedge clk)
    begin
        if (is_last)
        begin
            ring_mem[ptr_reg] <= wr_ent;
            rdata_reg         <= ring_mem[ptr_next];
        end
    end

    // Result beat; a one-record loop reads back the key just written.
    always_comb
    begin
        ring_t  back;
        logic   checked;
        back    = res_byp_reg ? '{rec: res_rec_reg, chain: res_chain_reg} : rdata_reg;
        checked = res_filled_reg && (back.chain == res_chain_reg);
        out_valid               = res_valid_reg;
        out_data.current_record = res_rec_reg;
        out_data.plus_ok        = res_plus_reg;
        out_data.back_checked   = checked;
        out_data.back_record    = res_filled_reg ? back.rec : 32'd0;
        out_data.back_remove    = checked && !res_minus_reg;
        out_data.table_overflow = res_ovf_reg;
    end

endmodule
`default_nettype wire

[sv/distance_constraint_record_filter_core.sv]
// Top level of the distance constraint record filter: registers, front end and back end.
// Path: a last-element beat passes the front-end queue, then the back end's result register.
// Throughput: one beat per cycle while out_stall is low; range checks are combinational.
// The two-entry queue between front and back absorbs a stall on the result side.
// Reset: asynchronous, active low; clears counts, flags, ring pointer and queue.
// Tables and the key ring hold no reset and need no clearing pass.
`default_nettype none
module distance_constraint_record_filter_core
    import dcrf_pkg::*;
#(
    parameter int MAX_CONSTRAINTS = DEF_MAX_CONSTRAINTS,
    parameter int MAX_LOOP        = DEF_MAX_LOOP,
    parameter int MAX_SIDE        = DEF_MAX_SIDE
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [6:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire in_t        in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_t            out_data
);

    cfg_t       cfg_reg;
    logic       cmd_valid;
    cmd_t       cmd;
    logic       cmd_pop;
    logic [1:0] level;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.loop_length        <= 7'd1;
            cfg_reg.distances_per_side <= 6'd20;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_LOOP_LENGTH)
                cfg_reg.loop_length <= cfg_data;
            else if (cfg_index == REG_DIST_SIDE)
                cfg_reg.distances_per_side <= cfg_data[5:0];
        end
    end

    dcrf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .level     (level)
    );

    dcrf_back #(
        .MAX_CONSTRAINTS (MAX_CONSTRAINTS),
        .MAX_LOOP        (MAX_LOOP),
        .MAX_SIDE        (MAX_SIDE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // A removal is only ever flagged on a checked back record.
    a_remove_checked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.back_remove || out_data.back_checked))
        else $error("back_remove without back_checked");

    // The queue never overfills and stalls input exactly when full.
    a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
        (level != 2'd3) && (in_stall == (level == 2'd2)))
        else $error("queue level inconsistent with input stall");

    // A queued beat is taken whenever the result stage is free.
    a_queue_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !out_valid) |-> cmd_pop)
        else $error("queue not drained while result stage empty");
`endif

endmodule
`default_nettype wire
